// ===== rtl/wnm_pkg.sv =====
// Shared types, constants and helpers for the wildcard name matcher.
// Used by wnm_pat_store, wnm_pos_engine and wildcard_name_matcher.
`default_nettype none

package wnm_pkg;

   localparam int PATTERN_DEPTH = 32;
   localparam int POS_W         = PATTERN_DEPTH + 1;
   localparam int CNT_W         = $clog2(PATTERN_DEPTH + 1);
   localparam int IDX_W         = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   localparam logic [7:0] ANY_RUN  = 8'd42;   // '*'
   localparam logic [7:0] ANY_ONE  = 8'd63;   // '?'
   localparam logic [7:0] LOWER_A  = 8'd97;
   localparam logic [7:0] LOWER_Z  = 8'd122;
   localparam logic [7:0] CASE_GAP = 8'd32;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_NAME   = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic       last_of_name;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // Store view handed to the position engine.
   typedef struct packed {
      logic [PATTERN_DEPTH-1:0] star;
      logic [PATTERN_DEPTH-1:0] hit;
      logic [POS_W-1:0]         head;
      logic [CNT_W-1:0]         count;
      logic                     overflow;
   } pat_view_type;

   // Pattern-side command from the control stage.
   typedef struct packed {
      logic       go;
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic       last_of_name;
   } cmd_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && b >= LOWER_A && b <= LOWER_Z) begin
         r = b - CASE_GAP;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wildcard_name_matcher.sv =====
// Wildcard name matcher, top level: input register, output register, case-fold CSR.
// Depends on wnm_pkg, wnm_pat_store and wnm_pos_engine.
//
// Load a pattern of up to 32 bytes ('*' any run, '?' any one byte) with clear and
// append items, then stream name bytes, one item per clock while req_stall is low.
// The final byte of each name (last_of_name) yields one result: matched, or
// pattern_overflow with matched low if more than 32 pattern bytes were appended
// since the last clear. Clear and append abandon a name in progress; opcode 3 is
// ignored. An item is taken every cycle unless a result waits on rsp_stall: every
// pattern position updates at once in a single pass between the input register
// and the result register. csr_wdata sets case folding of ASCII letters (reset: on).
// The user writes it only while the block is idle; the block does not enforce this.
`default_nettype none

module wildcard_name_matcher (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire wnm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output wnm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata
);

   wnm_pkg::req_type      in_ff, in_in;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   wnm_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  case_fold_ff, case_fold_in;
   logic                  has_result, out_free, go;
   wnm_pkg::cmd_type      cmd;
   wnm_pkg::pat_view_type view;
   wnm_pkg::rsp_type      result;

   assign has_result = (in_ff.opcode == wnm_pkg::OP_NAME) && in_ff.last_of_name;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign go         = in_valid_ff && (!has_result || out_free);
   assign req_stall  = in_valid_ff && !go;

   assign cmd.go           = go;
   assign cmd.opcode       = in_ff.opcode;
   assign cmd.data_byte    = in_ff.data_byte;
   assign cmd.last_of_name = in_ff.last_of_name;

   wnm_pat_store u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .case_fold (case_fold_ff),
      .view      (view)
   );

   wnm_pos_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .view   (view),
      .result (result)
   );

   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      case_fold_in = csr_we ? csr_wdata : case_fold_ff;

      if (req_valid && !req_stall) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      // hold a stalled result, load a new one when the slot frees
      if (go && has_result) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case_fold_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         case_fold_ff <= case_fold_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/wnm_pat_store.sv =====
// Pattern store: bytes, fill count, overflow flag and the leading-star set.
// Also compares every stored byte against the current name byte.
// Depends on wnm_pkg.
`default_nettype none

module wnm_pat_store (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wnm_pkg::cmd_type  cmd,
   input  wire logic              case_fold,
   output wnm_pkg::pat_view_type  view
);

   logic [7:0]                   store_ff [wnm_pkg::PATTERN_DEPTH];
   logic [wnm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         overflow_ff, overflow_in;
   logic [wnm_pkg::POS_W-1:0]    head_ff, head_in;
   logic                         wr_en;
   logic [wnm_pkg::IDX_W-1:0]    wr_idx;
   logic                         room;
   logic [7:0]                   name_c;

   assign room   = count_ff < wnm_pkg::CNT_W'(wnm_pkg::PATTERN_DEPTH);
   assign wr_en  = cmd.go && (cmd.opcode == wnm_pkg::OP_APPEND) && room;
   assign wr_idx = count_ff[wnm_pkg::IDX_W-1:0];
   assign name_c = wnm_pkg::fold_byte(cmd.data_byte, case_fold);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      head_in     = head_ff;
      if (cmd.go) begin
         case (cmd.opcode)
            wnm_pkg::OP_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
               head_in     = wnm_pkg::POS_W'(1);
            end
            wnm_pkg::OP_APPEND: begin
               if (room) begin
                  count_in = count_ff + 1'b1;
                  // extend the leading run of stars by one position
                  for (int j = 0; j < wnm_pkg::PATTERN_DEPTH; j++) begin
                     if (wnm_pkg::CNT_W'(j) == count_ff && head_ff[j]
                         && cmd.data_byte == wnm_pkg::ANY_RUN) begin
                        head_in[j+1] = 1'b1;
                     end
                  end
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         head_ff     <= wnm_pkg::POS_W'(1);
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         head_ff     <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= cmd.data_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < wnm_pkg::PATTERN_DEPTH; i++) begin
         logic live;
         live = wnm_pkg::CNT_W'(i) < count_ff;
         view.star[i] = live && (store_ff[i] == wnm_pkg::ANY_RUN);
         view.hit[i]  = live && (store_ff[i] != wnm_pkg::ANY_RUN)
                        && ((store_ff[i] == wnm_pkg::ANY_ONE)
                            || (wnm_pkg::fold_byte(store_ff[i], case_fold) == name_c));
      end
      view.head     = head_ff;
      view.count    = count_ff;
      view.overflow = overflow_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/wnm_pos_engine.sv =====
// Active pattern position set: one step per name byte, star closure by carry add.
// Depends on wnm_pkg and the view from wnm_pat_store.
`default_nettype none

module wnm_pos_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wnm_pkg::cmd_type      cmd,
   input  wire wnm_pkg::pat_view_type view,
   output wnm_pkg::rsp_type           result
);

   logic [wnm_pkg::POS_W-1:0] active_ff, active_in;
   logic                      start_ff, start_in;
   logic [wnm_pkg::POS_W-1:0] cur, stepped, star_m, gen, sum, carry, closed;

   assign star_m = {1'b0, view.star};
   assign cur    = start_ff ? view.head : active_ff;

   // stars hold their position, other hits advance by one
   assign stepped = (cur & star_m)
                    | {(cur[wnm_pkg::PATTERN_DEPTH-1:0] & view.hit), 1'b0};

   // closure: a live star also lights the next position; chains ripple as carries
   assign gen    = stepped & star_m;
   assign sum    = star_m + gen;
   assign carry  = sum ^ star_m ^ gen;
   assign closed = stepped | carry;

   assign result.matched          = !view.overflow && closed[view.count];
   assign result.pattern_overflow = view.overflow;

   always_comb begin
      active_in = active_ff;
      start_in  = start_ff;
      if (cmd.go) begin
         case (cmd.opcode)
            wnm_pkg::OP_CLEAR, wnm_pkg::OP_APPEND: begin
               active_in = '0;
               start_in  = 1'b1;
            end
            wnm_pkg::OP_NAME: begin
               if (cmd.last_of_name) begin
                  active_in = '0;
                  start_in  = 1'b1;
               end else begin
                  active_in = closed;
                  start_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         start_ff  <= 1'b1;
      end else begin
         active_ff <= active_in;
         start_ff  <= start_in;
      end
   end

endmodule

`default_nettype wire
